[design/mcuf_pkg.sv]
// ----------------------------------------------------------------------------
// mcuf_pkg
// Shared types, register map and helpers for the MUSCL MC-limited face block.
// ----------------------------------------------------------------------------
package mcuf_pkg;

  localparam int unsigned VEL_WIDTH = 32;
  localparam int unsigned ADDR_WIDTH = 3;
  localparam int unsigned DATA_WIDTH = 32;

  // register index as decoded from paddr[2]
  localparam logic REG_SLOPE_EN = 1'b0;

  typedef enum logic [1:0] {
    VEL_ZERO = 2'd0,
    VEL_POS  = 2'd1,
    VEL_NEG  = 2'd2
  } vel_sign_t;

  function automatic vel_sign_t vel_sign(input logic [VEL_WIDTH-1:0] v);
    vel_sign_t s;
    if (v == '0) begin
      s = VEL_ZERO;
    end else if (v[VEL_WIDTH-1]) begin
      s = VEL_NEG;
    end else begin
      s = VEL_POS;
    end
    return s;
  endfunction

endpackage

[design/mcuf_slope.sv]
// ----------------------------------------------------------------------------
// mcuf_slope
// Slope of the middle cell of a three-cell window: MC-limited when the window
// is full, one-sided when only the previous cell is known, zero when off.
// ----------------------------------------------------------------------------
module mcuf_slope
  import mcuf_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          limit_on,
  input  logic                          one_sided,
  input  logic signed [VALUE_WIDTH-1:0] older,
  input  logic signed [VALUE_WIDTH-1:0] prev,
  input  logic signed [VALUE_WIDTH-1:0] cur,
  output logic signed [VALUE_WIDTH+1:0] slope,
  output logic signed [VALUE_WIDTH+1:0] edge_slope
);

  localparam int unsigned W = VALUE_WIDTH;

  logic signed [W:0]   dwl;
  logic signed [W:0]   dwr;
  logic signed [W+1:0] dsum;
  logic signed [W:0]   dwc;
  logic        [W:0]   adl;
  logic        [W:0]   adr;
  logic        [W:0]   adc;
  logic        [W:0]   amin;
  logic        [W+1:0] lim2;
  logic        [W+1:0] mag;
  logic                opposite;
  logic signed [W+1:0] mc;
  logic signed [W+1:0] diff_ext;

  always_comb begin
    dwl  = {prev[W-1], prev} - {older[W-1], older};
    dwr  = {cur[W-1], cur} - {prev[W-1], prev};
    dsum = {dwl[W], dwl} + {dwr[W], dwr};
    dwc  = dsum[W+1:1];  // floor of half
    adl  = dwl[W] ? (~dwl + 1'b1) : dwl;
    adr  = dwr[W] ? (~dwr + 1'b1) : dwr;
    adc  = dwc[W] ? (~dwc + 1'b1) : dwc;
    amin = (adl < adr) ? adl : adr;
    lim2 = {amin, 1'b0};
    mag  = ({1'b0, adc} < lim2) ? {1'b0, adc} : lim2;
    opposite = (dwl[W] && (dwr != '0) && !dwr[W]) ||
               (dwr[W] && (dwl != '0) && !dwl[W]);
    if (opposite || dwc == '0) begin
      mc = '0;
    end else if (dwc[W]) begin
      mc = -$signed(mag);
    end else begin
      mc = $signed(mag);
    end
    diff_ext = {dwr[W], dwr};
    if (!limit_on) begin
      slope      = '0;
      edge_slope = '0;
    end else begin
      slope      = one_sided ? diff_ext : mc;
      edge_slope = diff_ext;
    end
  end

endmodule

[design/mcuf_face.sv]
// ----------------------------------------------------------------------------
// mcuf_face
// Upwind face value from the reconstructed left and right states, saturated.
// ----------------------------------------------------------------------------
module mcuf_face
  import mcuf_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic signed [VALUE_WIDTH+1:0] left_slope,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  input  logic signed [VALUE_WIDTH+1:0] right_slope,
  input  vel_sign_t                     sgn,
  output logic        [VALUE_WIDTH-1:0] face
);

  localparam int unsigned W = VALUE_WIDTH;

  logic signed [W+1:0] left_st;
  logic signed [W+1:0] right_st;
  logic signed [W+2:0] st_sum;
  logic signed [W+1:0] f;

  always_comb begin
    left_st  = {{2{left_value[W-1]}}, left_value} +
               {left_slope[W+1], left_slope[W+1:1]};
    right_st = {{2{right_value[W-1]}}, right_value} -
               {right_slope[W+1], right_slope[W+1:1]};
    st_sum   = {left_st[W+1], left_st} + {right_st[W+1], right_st};
    case (sgn)
      VEL_POS: f = left_st;
      VEL_NEG: f = right_st;
      default: f = st_sum[W+2:1];
    endcase
    // in range when the three top bits agree
    if (f[W+1:W-1] == 3'b000 || f[W+1:W-1] == 3'b111) begin
      face = f[W-1:0];
    end else if (f[W+1]) begin
      face = {1'b1, {(W-1){1'b0}}};
    end else begin
      face = {1'b0, {(W-1){1'b1}}};
    end
  end

endmodule

[design/mcuf_fifo.sv]
// ----------------------------------------------------------------------------
// mcuf_fifo
// Four-entry result queue taking up to two entries per cycle, one out.
// ----------------------------------------------------------------------------
module mcuf_fifo
  import mcuf_pkg::*;
#(
  parameter int unsigned DATA_W = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_cnt,
  input  logic [DATA_W-1:0] push_d0,
  input  logic [DATA_W-1:0] push_d1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0] mem [4];
  logic [1:0]        wr_ptr;
  logic [1:0]        rd_ptr;
  logic [2:0]        count;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push_cnt} - {2'b00, pop};
    end
  end

endmodule

[design/muscl_mc_limited_upwind_faces.sv]
// ----------------------------------------------------------------------------
// muscl_mc_limited_upwind_faces
// MUSCL face reconstruction along a grid line with MC limiter and upwinding.
// ----------------------------------------------------------------------------
// Timing: a taken cell is held in the input register and evaluated there once
// the queue has room; its faces are written to the result queue and offered.
// Throughput: one cell per cycle while the queue has room; the single output
// port sends a line-end cell's two faces one after the other.
// Reset (synchronous rst): window empty, queue empty, slope_en = 1.
module muscl_mc_limited_upwind_faces
  import mcuf_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_WIDTH-1:0]         paddr,
  input  logic [DATA_WIDTH-1:0]         pwdata,
  output logic [DATA_WIDTH-1:0]         prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] cell_value,
  input  logic signed [VEL_WIDTH-1:0]   low_face_velocity,
  input  logic                          line_first,
  input  logic                          line_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] face_value,
  output logic                          last_of_run
);

  localparam int unsigned W = VALUE_WIDTH;

  logic slope_en;

  // input register
  logic                  s0_valid;
  logic signed [W-1:0]   s0_value;
  logic [VEL_WIDTH-1:0]  s0_vel;
  logic                  s0_first;
  logic                  s0_last;
  logic                  s0_fire;

  // line window
  logic signed [W-1:0]   older_value;
  logic signed [W-1:0]   previous_value;
  logic signed [W+1:0]   older_slope;
  logic [VEL_WIDTH-1:0]  pending_velocity;
  logic [1:0]            cells_seen;

  logic                  start_new;
  logic                  res_a;
  logic                  res_b;
  logic signed [W+1:0]   sp;
  logic signed [W+1:0]   sc;
  logic [W-1:0]          face_a;
  logic [W-1:0]          face_b;
  logic                  room;
  logic [1:0]            push_cnt;
  logic [W:0]            push_d0;
  logic [W:0]            push_d1;
  logic [W:0]            out_data;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLOPE_EN) ?
                  {{(DATA_WIDTH-1){1'b0}}, slope_en} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_en <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_SLOPE_EN) begin
      slope_en <= pwdata[0];
    end
  end

  // input stage
  assign s0_fire  = s0_valid && room;
  assign in_ready = !s0_valid || s0_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_value <= cell_value;
      s0_vel   <= low_face_velocity;
      s0_first <= line_first;
      s0_last  <= line_last;
    end
  end

  // evaluation
  assign start_new = s0_first || cells_seen == 2'd0;
  assign res_a     = !start_new && cells_seen == 2'd2;
  assign res_b     = !start_new && s0_last;

  mcuf_slope #(
    .VALUE_WIDTH (W)
  ) u_slope (
    .limit_on   (slope_en),
    .one_sided  (cells_seen == 2'd1),
    .older      (older_value),
    .prev       (previous_value),
    .cur        (s0_value),
    .slope      (sp),
    .edge_slope (sc)
  );

  mcuf_face #(
    .VALUE_WIDTH (W)
  ) u_face_low (
    .left_value  (older_value),
    .left_slope  (older_slope),
    .right_value (previous_value),
    .right_slope (sp),
    .sgn         (vel_sign(pending_velocity)),
    .face        (face_a)
  );

  mcuf_face #(
    .VALUE_WIDTH (W)
  ) u_face_high (
    .left_value  (previous_value),
    .left_slope  (sp),
    .right_value (s0_value),
    .right_slope (sc),
    .sgn         (vel_sign(s0_vel)),
    .face        (face_b)
  );

  always_comb begin
    push_cnt = 2'd0;
    push_d0  = {1'b1, face_b};
    push_d1  = {1'b1, face_b};
    if (s0_fire) begin
      push_cnt = {1'b0, res_a} + {1'b0, res_b};
      if (res_a) begin
        push_d0 = {!res_b, face_a};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_value      <= '0;
      previous_value   <= '0;
      older_slope      <= '0;
      pending_velocity <= '0;
      cells_seen       <= '0;
    end else if (s0_fire) begin
      if (start_new) begin
        previous_value <= s0_value;
        cells_seen     <= s0_last ? 2'd0 : 2'd1;
      end else if (s0_last) begin
        cells_seen <= 2'd0;
      end else begin
        older_value      <= previous_value;
        older_slope      <= sp;
        previous_value   <= s0_value;
        pending_velocity <= s0_vel;
        cells_seen       <= 2'd2;
      end
    end
  end

  mcuf_fifo #(
    .DATA_W (W + 1)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push_d0   (push_d0),
    .push_d1   (push_d1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign face_value  = out_data[W-1:0];
  assign last_of_run = out_data[W];

endmodule

[test/mcuf_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcuf_checker
// Watches the cell, face and register channels of the MUSCL face block.
// Predicts each face from the accepted cells and compares it in order.
// ----------------------------------------------------------------------------
module mcuf_checker
  import mcuf_pkg::*;
#(
  parameter int unsigned VW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  input  logic [DATA_WIDTH-1:0] prdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic signed [VW-1:0]  cell_value,
  input  logic [VEL_WIDTH-1:0]  low_face_velocity,
  input  logic                  line_first,
  input  logic                  line_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [VW-1:0]  face_value,
  input  logic                  last_of_run,
  output int                    pending,
  output int                    failures
);

  // wide enough for differences of differences and the face sums
  typedef logic signed [VW+3:0] wide_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 last;
  } face_t;

  localparam wide_t FACE_MAX = (wide_t'(1) <<< (VW - 1)) - 1;
  localparam wide_t FACE_MIN = -FACE_MAX - 1;

  face_t expected_faces[$];
  int    fail_count = 0;
  int    waiting = 0;

  // line window
  logic                 limit_on;
  wide_t                older_cell;
  wide_t                newest_cell;
  wide_t                older_slope;
  logic [VEL_WIDTH-1:0] between_vel;
  logic [1:0]           window_fill;

  assign failures = fail_count;
  assign pending = waiting;

  // floor of x / 2
  function automatic wide_t halve(input wide_t x);
    return x >>> 1;
  endfunction

  function automatic wide_t mag(input wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic wide_t mc_limited_slope(input wide_t o, input wide_t p, input wide_t c);
    wide_t dl, dr, dc, cap;
    dl = p - o;
    dr = c - p;
    dc = halve(dl + dr);
    if ((dl < 0 && dr > 0) || (dl > 0 && dr < 0)) begin
      return 0;
    end
    cap = (mag(dl) < mag(dr)) ? mag(dl) : mag(dr);
    cap = cap <<< 1;
    if (mag(dc) < cap) begin
      cap = mag(dc);
    end
    if (dc > 0) begin
      return cap;
    end else if (dc < 0) begin
      return -cap;
    end
    return 0;
  endfunction

  function automatic logic signed [VW-1:0] upwind_face(input wide_t vl, input wide_t sl,
                                                      input wide_t vr, input wide_t sr,
                                                      input logic [VEL_WIDTH-1:0] vel);
    wide_t     left_state, right_state, f;
    vel_sign_t dir;
    left_state = vl + halve(sl);
    right_state = vr - halve(sr);
    if (vel == '0) begin
      dir = VEL_ZERO;
    end else if (vel[VEL_WIDTH-1]) begin
      dir = VEL_NEG;
    end else begin
      dir = VEL_POS;
    end
    case (dir)
      VEL_POS: f = left_state;
      VEL_NEG: f = right_state;
      default: f = halve(left_state + right_state);
    endcase
    if (f > FACE_MAX) begin
      f = FACE_MAX;
    end else if (f < FACE_MIN) begin
      f = FACE_MIN;
    end
    return f[VW-1:0];
  endfunction

  task automatic expect_face(input logic signed [VW-1:0] value, input logic last);
    face_t item;
    item.value = value;
    item.last = last;
    expected_faces.push_back(item);
  endtask

  task automatic take_cell(input wide_t v, input logic [VEL_WIDTH-1:0] vel,
                           input logic first, input logic last);
    wide_t new_slope, end_slope;
    if (first || window_fill == 2'd0) begin
      // start of a line; anything held for an unfinished line is dropped
      newest_cell = v;
      window_fill = last ? 2'd0 : 2'd1;
    end else begin
      if (!limit_on) begin
        new_slope = 0;
      end else if (window_fill == 2'd1) begin
        new_slope = v - newest_cell;
      end else begin
        new_slope = mc_limited_slope(older_cell, newest_cell, v);
      end
      if (window_fill == 2'd2) begin
        expect_face(upwind_face(older_cell, older_slope, newest_cell, new_slope, between_vel),
                    !last);
      end
      if (last) begin
        end_slope = limit_on ? v - newest_cell : 0;
        expect_face(upwind_face(newest_cell, new_slope, v, end_slope, vel), 1'b1);
        window_fill = 2'd0;
      end else begin
        older_cell = newest_cell;
        older_slope = new_slope;
        newest_cell = v;
        between_vel = vel;
        window_fill = 2'd2;
      end
    end
  endtask

  always @(posedge clk) begin
    face_t want;
    if (rst) begin
      limit_on = 1'b1;
      older_cell = 0;
      newest_cell = 0;
      older_slope = 0;
      between_vel = '0;
      window_fill = 2'd0;
      expected_faces.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_faces.size() == 0) begin
          $error("face transaction with nothing expected: face_value %0d last_of_run %0b",
                 face_value, last_of_run);
          fail_count++;
        end else begin
          want = expected_faces.pop_front();
          if (face_value !== want.value) begin
            $error("face_value expected %0d actual %0d", want.value, face_value);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run expected %0b actual %0b", want.last, last_of_run);
            fail_count++;
          end
        end
      end
      if (psel && penable && pready && paddr[2] == REG_SLOPE_EN) begin
        if (pwrite) begin
          limit_on = pwdata[0];
        end else if (prdata !== {{(DATA_WIDTH-1){1'b0}}, limit_on}) begin
          $error("slope_en expected %0h actual %0h", limit_on, prdata);
          fail_count++;
        end
      end
      if (in_valid && in_ready) begin
        take_cell(wide_t'(cell_value), low_face_velocity, line_first, line_last);
      end
    end
    waiting <= expected_faces.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives grid lines of cells into the MUSCL face block under both limiter
// settings, with random gaps on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module tb
  import mcuf_pkg::*;
();

  localparam int unsigned VW = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned CELLS_PER_PHASE = 170;
  localparam logic [ADDR_WIDTH-1:0] LIMIT_ADDR = {REG_SLOPE_EN, 2'b00};
  localparam logic signed [VW-1:0] CELL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] CELL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VEL_WIDTH-1:0] VEL_MAX = {1'b0, {(VEL_WIDTH-1){1'b1}}};
  localparam logic [VEL_WIDTH-1:0] VEL_MIN = {1'b1, {(VEL_WIDTH-1){1'b0}}};
  localparam logic [VEL_WIDTH-1:0] VEL_MINUS_ONE = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [VW-1:0]  cell_value = '0;
  logic [VEL_WIDTH-1:0]  low_face_velocity = '0;
  logic                  line_first = 1'b0;
  logic                  line_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [VW-1:0]  face_value;
  logic                  last_of_run;

  int          pending;
  int          failures;
  int unsigned cycles = 0;
  int          idle_pct = 22;
  bit          long_hold = 1'b0;
  bit          hold_done = 1'b0;
  bit          limit_per_phase[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  always #2 clk = ~clk;

  muscl_mc_limited_upwind_faces #(.VALUE_WIDTH(VW)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .cell_value(cell_value), .low_face_velocity(low_face_velocity),
    .line_first(line_first), .line_last(line_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .face_value(face_value), .last_of_run(last_of_run)
  );

  mcuf_checker #(.VW(VW)) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .cell_value(cell_value), .low_face_velocity(low_face_velocity),
    .line_first(line_first), .line_last(line_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .face_value(face_value), .last_of_run(last_of_run),
    .pending(pending), .failures(failures)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // face receiver: random stalls, one long hold-off while cells keep coming
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  task automatic send_cell(input logic signed [VW-1:0] v, input logic [VEL_WIDTH-1:0] vel,
                           input logic first, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_value <= v;
    low_face_velocity <= vel;
    line_first <= first;
    line_last <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // let every expected face out, then wait out cells still in flight
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(input logic write, input logic [DATA_WIDTH-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= LIMIT_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [VEL_WIDTH-1:0] random_velocity();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return VEL_MIN;
      3:       return VEL_MAX;
      4:       return 1;
      5:       return VEL_MINUS_ONE;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed lines with smooth or rough profiles, some noise cells,
  // lines missing their first mark and lines cut off by the next one
  task automatic random_cells(input int quota);
    int                   sent;
    int                   len;
    int                   k;
    int                   sh;
    bit                   rough;
    bit                   drop_first;
    bit                   cut_short;
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] trend;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 99) < 8) begin
        send_cell($urandom, random_velocity(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        rough = ($urandom_range(0, 4) == 0);
        drop_first = ($urandom_range(0, 19) == 0);
        cut_short = ($urandom_range(0, 11) == 0);
        v = $urandom;
        sh = $urandom_range(0, 31);
        trend = $signed($urandom) >>> sh;
        for (k = 0; k < len; k++) begin
          send_cell(v, random_velocity(), (k == 0) && !drop_first, (k == len - 1) && !cut_short);
          sent++;
          if (rough) begin
            v = $urandom;
          end else begin
            v = v + trend + ($signed($urandom) >>> $urandom_range(sh, 31));
          end
          if ($urandom_range(0, 29) == 0) begin
            v = $urandom_range(0, 1) ? CELL_MAX : CELL_MIN;
          end
        end
      end
    end
  endtask

  initial begin
    int ph;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_access(1'b0, '0);

    // single-cell line, then a line that starts without its first mark
    send_cell(7 <<< 16, '0, 1'b1, 1'b1);
    send_cell(1 <<< 16, 5, 1'b0, 1'b0);
    send_cell(3 <<< 16, 1, 1'b0, 1'b0);
    send_cell(2 <<< 16, VEL_MINUS_ONE, 1'b0, 1'b0);
    send_cell(2 <<< 16, '0, 1'b0, 1'b0);
    send_cell(5 <<< 16, VEL_MAX, 1'b0, 1'b1);
    // saturating faces
    send_cell(CELL_MAX, '0, 1'b1, 1'b0);
    send_cell(CELL_MIN, VEL_MIN, 1'b0, 1'b0);
    send_cell(CELL_MAX, VEL_MAX, 1'b0, 1'b0);
    send_cell(CELL_MIN, 1, 1'b0, 1'b0);
    send_cell(CELL_MAX, VEL_MINUS_ONE, 1'b0, 1'b1);
    // two-cell line
    send_cell(CELL_MIN, '0, 1'b1, 1'b0);
    send_cell(CELL_MAX, 1, 1'b0, 1'b1);
    // new line starts before the old one ends
    send_cell('0, '0, 1'b1, 1'b0);
    send_cell(-1, -5, 1'b0, 1'b0);
    send_cell(4 <<< 16, 3, 1'b0, 1'b0);
    send_cell(100, 7, 1'b1, 1'b0);
    send_cell(200, -7, 1'b0, 1'b0);
    send_cell(32'h0001_8000, '0, 1'b0, 1'b1);
    // zigzag and steep ramp: limiter clips and zeroes slopes
    send_cell('0, '0, 1'b1, 1'b0);
    send_cell(10 <<< 16, 1, 1'b0, 1'b0);
    send_cell('0, VEL_MINUS_ONE, 1'b0, 1'b0);
    send_cell(10 <<< 16, '0, 1'b0, 1'b0);
    send_cell(40 <<< 16, 1, 1'b0, 1'b1);

    for (ph = 0; ph < 6; ph++) begin
      drain();
      reg_access(1'b1, {{(DATA_WIDTH-1){1'b0}}, limit_per_phase[ph]});
      reg_access(1'b0, '0);
      idle_pct = (ph == 3) ? 0 : 22;
      if (ph == 1) begin
        long_hold = 1'b1;
      end
      random_cells(CELLS_PER_PHASE);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
